[hdl/sra_pkg.sv]
// Shared types, constants and tables for the sliding regression angle unit.
// No dependencies; used by every module of the block by scoped names.
package sra_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int ADDR_W      = $clog2(MAX_WINDOW);
    localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
    localparam int CFG_W       = 7;
    localparam int SAMPLE_W    = 32;
    localparam int SUMY_W      = 38;
    localparam int SUMW_W      = 44;
    localparam int S_W         = 2 * CNT_W;
    localparam int NUM_W       = 56;
    localparam int DEN_W       = 22;
    localparam int ANGLE_W     = 24;
    localparam int CORDIC_W    = 62;
    localparam int Z_W         = 33;
    localparam int STEPS       = 26;
    localparam int STEP_W      = 5;
    localparam int WL_RESET    = 14;
    localparam int ANGLE_MAX   = 5898240;

    typedef logic [DEN_W-1:0] t_den_tab [0:MAX_WINDOW];

    function automatic t_den_tab build_den_tab();
        t_den_tab t;
        longint   k;
        for (int i = 0; i <= MAX_WINDOW; i++) begin
            k    = longint'(i);
            t[i] = DEN_W'((k * k * (k * k - 1)) / 12);
        end
        return t;
    endfunction

    localparam t_den_tab DEN_TAB = build_den_tab();

    // atan(2^-i) in degrees, Q24
    function automatic logic [Z_W-1:0] atan_q24(input logic [STEP_W-1:0] i);
        logic [Z_W-1:0] r;
        unique case (i)
            5'd0:    r = 33'd754974720;
            5'd1:    r = 33'd445687602;
            5'd2:    r = 33'd235489088;
            5'd3:    r = 33'd119537938;
            5'd4:    r = 33'd60000934;
            5'd5:    r = 33'd30029717;
            5'd6:    r = 33'd15018523;
            5'd7:    r = 33'd7509720;
            5'd8:    r = 33'd3754917;
            5'd9:    r = 33'd1877466;
            5'd10:   r = 33'd938734;
            5'd11:   r = 33'd469367;
            5'd12:   r = 33'd234684;
            5'd13:   r = 33'd117342;
            5'd14:   r = 33'd58671;
            5'd15:   r = 33'd29335;
            5'd16:   r = 33'd14668;
            5'd17:   r = 33'd7334;
            5'd18:   r = 33'd3667;
            5'd19:   r = 33'd1833;
            5'd20:   r = 33'd917;
            5'd21:   r = 33'd458;
            5'd22:   r = 33'd229;
            5'd23:   r = 33'd115;
            5'd24:   r = 33'd57;
            5'd25:   r = 33'd29;
            default: r = '0;
        endcase
        return r;
    endfunction

    typedef struct packed {
        logic signed [NUM_W-1:0] num;
        logic        [DEN_W-1:0] den;
    } t_job;

endpackage

[hdl/sra_front.sv]
// Front end: takes samples, keeps the ring and the running sums, forms num/den.
// Depends on sra_pkg.
module sra_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [sra_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                               i_start,
    input  logic                               i_cfg_wr_en,
    input  logic [sra_pkg::CFG_W-1:0]          i_cfg_wr_data,
    output logic                               o_push,
    output sra_pkg::t_job                      o_job,
    input  logic                               i_full
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_UPD  = 2'd1;
    localparam logic [1:0] F_MUL  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]                              r_state;
    logic [sra_pkg::CFG_W-1:0]               r_wl;
    logic [sra_pkg::ADDR_W-1:0]              r_wp;
    logic [sra_pkg::CNT_W-1:0]               r_fill;
    logic signed [sra_pkg::SUMY_W-1:0]       r_y;
    logic signed [sra_pkg::SUMW_W-1:0]       r_w;
    logic signed [sra_pkg::SAMPLE_W-1:0]     r_v;
    logic signed [sra_pkg::SAMPLE_W-1:0]     r_old;
    logic                                    r_full;
    logic signed [sra_pkg::NUM_W-1:0]        r_p1;
    logic signed [sra_pkg::NUM_W-1:0]        r_p2;
    logic signed [sra_pkg::SAMPLE_W-1:0]     r_ring [0:sra_pkg::MAX_WINDOW-1];

    logic [sra_pkg::CNT_W-1:0]               w_n;
    logic [sra_pkg::S_W-1:0]                 w_s;
    logic [sra_pkg::ADDR_W-1:0]              w_wp_eff;
    logic [sra_pkg::CNT_W-1:0]               w_fill_eff;
    logic [sra_pkg::ADDR_W-1:0]              w_oldest;
    logic                                    w_acc;
    logic signed [sra_pkg::SUMW_W-1:0]       w_nold;

    always_comb begin
        priority if (r_wl < sra_pkg::CFG_W'(2))
            w_n = sra_pkg::CNT_W'(2);
        else if (r_wl > sra_pkg::CFG_W'(sra_pkg::MAX_WINDOW))
            w_n = sra_pkg::CNT_W'(sra_pkg::MAX_WINDOW);
        else
            w_n = sra_pkg::CNT_W'(r_wl);
    end

    assign w_s        = (sra_pkg::S_W'(w_n) * (sra_pkg::S_W'(w_n) - sra_pkg::S_W'(1))) >> 1;
    assign o_ready    = (r_state == F_IDLE);
    assign w_acc      = i_valid && o_ready;
    assign w_wp_eff   = i_start ? '0 : r_wp;
    assign w_fill_eff = i_start ? '0 : r_fill;
    assign w_oldest   = w_wp_eff - w_n[sra_pkg::ADDR_W-1:0];
    assign w_nold     = $signed({{(sra_pkg::SUMW_W-sra_pkg::CNT_W){1'b0}}, w_n})
                        * sra_pkg::SUMW_W'(r_old);

    assign o_push     = (r_state == F_PUSH) && !i_full;
    assign o_job.num  = r_p1 - r_p2;
    assign o_job.den  = sra_pkg::DEN_TAB[w_n];

    // Ring: read the oldest entry before this sample overwrites it
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_old              <= r_ring[w_oldest];
            r_ring[w_wp_eff]   <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc)
            r_v <= i_sample;
        if (r_state == F_MUL) begin
            r_p1 <= $signed({{(sra_pkg::NUM_W-sra_pkg::S_W){1'b0}}, w_s})
                    * sra_pkg::NUM_W'(r_y);
            r_p2 <= $signed({{(sra_pkg::NUM_W-sra_pkg::CNT_W){1'b0}}, w_n})
                    * sra_pkg::NUM_W'(r_w);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_wl    <= sra_pkg::CFG_W'(sra_pkg::WL_RESET);
            r_wp    <= '0;
            r_fill  <= '0;
            r_y     <= '0;
            r_w     <= '0;
            r_full  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_wl    <= i_cfg_wr_data;
            r_wp    <= '0;
            r_fill  <= '0;
            r_y     <= '0;
            r_w     <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (w_acc) begin
                        r_full <= (w_fill_eff >= w_n);
                        if (w_fill_eff < w_n)
                            r_fill <= w_fill_eff + 1'b1;
                        else
                            r_fill <= w_fill_eff;
                        r_wp <= w_wp_eff + 1'b1;
                        if (i_start) begin
                            r_y <= '0;
                            r_w <= '0;
                        end
                        r_state <= F_UPD;
                    end
                end
                F_UPD: begin
                    if (r_full) begin
                        r_w <= r_w + sra_pkg::SUMW_W'(r_y) - w_nold;
                        r_y <= r_y + sra_pkg::SUMY_W'(r_v) - sra_pkg::SUMY_W'(r_old);
                    end else begin
                        r_w <= r_w + sra_pkg::SUMW_W'(r_y);
                        r_y <= r_y + sra_pkg::SUMY_W'(r_v);
                    end
                    r_state <= F_MUL;
                end
                F_MUL: begin
                    // drop items still in warm-up
                    r_state <= (r_fill >= w_n) ? F_PUSH : F_IDLE;
                end
                F_PUSH: begin
                    if (!i_full)
                        r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

[hdl/sra_queue.sv]
// Two-entry request queue between front and back ends.
// Depends on sra_pkg for the request type.
module sra_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sra_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output sra_pkg::t_job o_job
);

    sra_pkg::t_job r_q [0:1];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_q[r_wr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wr <= ~r_wr;
            if (i_pop)
                r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

[hdl/sra_back.sv]
// Back end: normalises num/den and runs a vectoring CORDIC for the angle.
// Depends on sra_pkg.
module sra_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_empty,
    input  sra_pkg::t_job                     i_job,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [sra_pkg::ANGLE_W-1:0]       o_angle
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_NORM = 2'd1;
    localparam logic [1:0] B_ROT  = 2'd2;
    localparam logic [1:0] B_FIN  = 2'd3;

    localparam int W = sra_pkg::CORDIC_W;

    logic [1:0]                        r_state;
    logic                              r_neg;
    logic                              r_zero;
    logic signed [W-1:0]               r_x;
    logic signed [W-1:0]               r_y;
    logic signed [sra_pkg::Z_W-1:0]    r_z;
    logic [sra_pkg::STEP_W-1:0]        r_i;
    logic                              r_ovalid;
    logic [sra_pkg::ANGLE_W-1:0]       r_angle;

    logic [W-1:0]                      w_big;
    logic signed [W-1:0]               w_xs;
    logic signed [W-1:0]               w_ys;
    logic [sra_pkg::Z_W-1:0]           w_atan;
    logic [sra_pkg::Z_W-1:0]           w_zc;
    logic [sra_pkg::Z_W-1:0]           w_zr;
    logic [sra_pkg::ANGLE_W-1:0]       w_mag;
    logic [sra_pkg::NUM_W-1:0]         w_abs;
    logic                              w_load;

    assign o_valid = r_ovalid;
    assign o_angle = r_angle;
    assign o_pop   = (r_state == B_IDLE) && !i_empty;
    assign w_load  = !r_ovalid || i_ready;

    assign w_abs  = i_job.num[sra_pkg::NUM_W-1] ? sra_pkg::NUM_W'(-i_job.num)
                                                : sra_pkg::NUM_W'(i_job.num);
    assign w_big  = (r_x > r_y) ? r_x : r_y;
    assign w_xs   = r_x >>> r_i;
    assign w_ys   = r_y >>> r_i;
    assign w_atan = sra_pkg::atan_q24(r_i);

    // clamp negative to zero, round half up to Q16, clamp to 90 degrees
    assign w_zc   = r_z[sra_pkg::Z_W-1] ? '0 : r_z;
    assign w_zr   = (w_zc + sra_pkg::Z_W'(128)) >> 8;
    assign w_mag  = (w_zr > sra_pkg::Z_W'(sra_pkg::ANGLE_MAX))
                    ? sra_pkg::ANGLE_W'(sra_pkg::ANGLE_MAX)
                    : sra_pkg::ANGLE_W'(w_zr);

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    r_neg  <= i_job.num[sra_pkg::NUM_W-1];
                    r_zero <= (i_job.num == '0);
                    r_y    <= W'(w_abs);
                    r_x    <= W'(i_job.den);
                    r_z    <= '0;
                    r_i    <= '0;
                end
            end
            B_NORM: begin
                priority if (w_big < (W'(1) << 51)) begin
                    r_x <= r_x <<< 8;
                    r_y <= r_y <<< 8;
                end else if (w_big < (W'(1) << 58)) begin
                    r_x <= r_x <<< 1;
                    r_y <= r_y <<< 1;
                end
            end
            B_ROT: begin
                if (r_y >= 0) begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_atan;
                end else begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_atan;
                end
                r_i <= r_i + 1'b1;
            end
            B_FIN: begin
                if (w_load)
                    r_angle <= r_zero ? '0 : (r_neg ? -w_mag : w_mag);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if ((r_state == B_FIN) && w_load)
                r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready)
                r_ovalid <= 1'b0;
            unique case (r_state)
                B_IDLE: if (!i_empty)
                    r_state <= (i_job.num == '0) ? B_FIN : B_NORM;
                B_NORM: if (w_big >= (W'(1) << 58))
                    r_state <= B_ROT;
                B_ROT:  if (r_i == sra_pkg::STEP_W'(sra_pkg::STEPS - 1))
                    r_state <= B_FIN;
                B_FIN: begin
                    if (w_load)
                        r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

[hdl/sliding_regression_angle_unit.sv]
// Sliding least-squares slope angle: top level joining front end, queue, back end.
// Depends on sra_pkg, sra_front, sra_queue and sra_back.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: sample_value; tuser: start_new_series
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: angle_degrees
//  cfg       in   i_cfg_wr_en                   i_cfg_wr_data: window_length
//
// The front end handles one sample at a time (ring read, sum update, products,
// request) and takes the next only once back in idle; a warm-up sample skips the
// request. The back end loads a request, normalises, runs the CORDIC and delivers
// the result; a flat window skips normalising and the CORDIC.
// Reset is synchronous and clears control state; ring contents stay unknown.
// A two-entry request queue lets the front run on while the back is busy;
// a stalled output holds the back end, and a full queue holds the front.
module sliding_regression_angle_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,   // [31:0] sample_value
    input  logic                              s_axis_tuser,   // [0] start_new_series
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [23:0]                       m_axis_tdata,   // [23:0] angle_degrees
    input  logic                              i_cfg_wr_en,
    input  logic [sra_pkg::CFG_W-1:0]         i_cfg_wr_data
);

    logic          w_push;
    logic          w_full;
    logic          w_pop;
    logic          w_empty;
    sra_pkg::t_job w_job_in;
    sra_pkg::t_job w_job_out;

    sra_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_sample      ($signed(s_axis_tdata)),
        .i_start       (s_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_push        (w_push),
        .o_job         (w_job_in),
        .i_full        (w_full)
    );

    sra_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_job   (w_job_out)
    );

    sra_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_job   (w_job_out),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_angle (m_axis_tdata)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full)) else $error("request queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_empty)) else $error("request queue underflow");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata) <= 24'sd5898240 &&
                           $signed(m_axis_tdata) >= -24'sd5898240))
        else $error("angle out of range");

endmodule
